// File: hdl/rmst_pkg.sv
// Package for the range maximum segment tree: sizes, request codes,
// the memory request struct and the max helper.
// No dependencies.
package rmst_pkg;

   localparam int LEAF_BITS  = 10;
   localparam int LEAVES     = 1 << LEAF_BITS;
   localparam int NODE_BITS  = LEAF_BITS + 1;
   localparam int NODES      = 2 * LEAVES;
   localparam int WALK_BITS  = NODE_BITS + 1;
   localparam int POS_BITS   = 11;
   localparam int VALUE_BITS = 31;

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef struct packed {
      logic                  wr_en;
      logic [NODE_BITS-1:0]  wr_addr;
      logic [VALUE_BITS-1:0] wr_data;
      logic                  rd_en;
      logic [NODE_BITS-1:0]  rd_addr;
   } mem_req_type;

   function automatic logic [VALUE_BITS-1:0] larger(
      input logic [VALUE_BITS-1:0] a,
      input logic [VALUE_BITS-1:0] b
   );
      return (a > b) ? a : b;
   endfunction

endpackage

// File: hdl/rmst_mem.sv
// Node store of the segment tree: one write port and one read port,
// read data registered. Depends on rmst_pkg.
module rmst_mem (
   input  logic                               clock,
   input  rmst_pkg::mem_req_type              mem_req,
   output logic [rmst_pkg::VALUE_BITS-1:0]    rd_data
);
   import rmst_pkg::*;

   logic [VALUE_BITS-1:0] node_max_ff [NODES];
   logic [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         node_max_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= node_max_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/rmst_ctrl.sv
// Sequencer of the segment tree: clearing pass, leaf-to-root raise walk
// and bottom-up range walk over the node store. Depends on rmst_pkg.
module rmst_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [rmst_pkg::POS_BITS-1:0]     req_position,
   input  logic [rmst_pkg::VALUE_BITS-1:0]   req_update_value,
   input  logic [rmst_pkg::POS_BITS-1:0]     req_range_low,
   input  logic [rmst_pkg::POS_BITS-1:0]     req_range_high,
   input  logic [rmst_pkg::POS_BITS-1:0]     leaf_count,
   output rmst_pkg::mem_req_type             mem_req,
   input  logic [rmst_pkg::VALUE_BITS-1:0]   rd_data,
   output logic                              rsp_valid,
   output logic [rmst_pkg::VALUE_BITS-1:0]   rsp_max_value
);
   import rmst_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_QUERY  = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [NODE_BITS-1:0]  node_ff, node_in;
   logic [WALK_BITS-1:0]  a_ff, a_in;
   logic [WALK_BITS-1:0]  b_ff, b_in;
   logic                  phase_ff, phase_in;
   logic                  pend_ff, pend_in;
   logic [NODE_BITS-1:0]  pend_addr_ff, pend_addr_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_max_ff, rsp_max_in;

   logic [POS_BITS-1:0]   size;
   logic [POS_BITS-1:0]   lo_clip;
   logic [POS_BITS-1:0]   hi_clip;
   logic                  pos_ok;
   logic [VALUE_BITS-1:0] folded;

   always_comb begin
      size    = (leaf_count > POS_BITS'(LEAVES)) ? POS_BITS'(LEAVES) : leaf_count;
      lo_clip = (req_range_low == '0) ? POS_BITS'(1) : req_range_low;
      hi_clip = (req_range_high > size) ? size : req_range_high;
      pos_ok  = (req_position != '0) && (req_position <= size);
      folded  = pend_ff ? larger(best_ff, rd_data) : best_ff;
   end

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      phase_in     = phase_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      value_in     = value_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_max_in   = rsp_max_ff;
      mem_req      = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = node_ff;
            mem_req.wr_data = '0;
            node_in         = node_ff + NODE_BITS'(1);
            if (node_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_UPDATE) begin
                  if (pos_ok) begin
                     node_in  = NODE_BITS'(LEAVES) + NODE_BITS'(req_position)
                                - NODE_BITS'(1);
                     value_in = req_update_value;
                     state_in = ST_UPDATE;
                  end
               end else begin
                  best_in  = '0;
                  phase_in = 1'b0;
                  state_in = ST_QUERY;
                  if (lo_clip > hi_clip) begin
                     a_in = '0;
                     b_in = '0;
                  end else begin
                     a_in = WALK_BITS'(LEAVES) + WALK_BITS'(lo_clip) - WALK_BITS'(1);
                     b_in = WALK_BITS'(LEAVES) + WALK_BITS'(hi_clip);
                  end
               end
            end
         end
         ST_UPDATE: begin
            // The tree stays consistent, so every ancestor simply takes the
            // larger of its own value and the new one.
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pend_addr_ff;
               mem_req.wr_data = larger(rd_data, value_ff);
            end
            if (node_ff != '0) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = node_ff;
               pend_in         = 1'b1;
               pend_addr_in    = node_ff;
               node_in         = node_ff >> 1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_QUERY: begin
            best_in = folded;
            if (!phase_ff) begin
               if (a_ff >= b_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_max_in   = folded;
                  state_in     = ST_IDLE;
               end else begin
                  if (a_ff[0]) begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = a_ff[NODE_BITS-1:0];
                     pend_in         = 1'b1;
                     a_in            = a_ff + WALK_BITS'(1);
                  end
                  phase_in = 1'b1;
               end
            end else begin
               if (b_ff[0]) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = NODE_BITS'(b_ff - WALK_BITS'(1));
                  pend_in         = 1'b1;
               end
               // An odd right edge drops by one first; the halving gives the
               // same parent either way.
               a_in     = a_ff >> 1;
               b_in     = b_ff >> 1;
               phase_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         node_ff      <= '0;
         phase_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff         <= a_in;
      b_ff         <= b_in;
      pend_addr_ff <= pend_addr_in;
      value_ff     <= value_in;
      best_ff      <= best_in;
      rsp_max_ff   <= rsp_max_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_max_ff;

endmodule

// File: hdl/range_max_segment_tree.sv
// Top level of the range maximum segment tree: size register, sequencer
// and node store. Depends on rmst_pkg, rmst_ctrl and rmst_mem.
//
// Usage: a request beat is taken at a clock edge with start high and busy
// low. req_type selects a raise-to-max update of req_position by
// req_update_value, or a maximum query over req_range_low..req_range_high.
// An update gives no response; an update outside 1..leaf_count, with
// leaf_count capped at 1024, is dropped and leaves busy low. A query
// gives exactly one response beat: rsp_valid is high for one cycle with
// rsp_max_value (0 for an empty range). The receiver cannot stall, so
// the response is simply presented once. An update does one read and
// one write-back per tree level while busy, pipelined over the single
// read and single write port. A query reads the edge nodes of the range
// level by level while busy, as the single read port takes one node per
// cycle. After reset the 2048-entry node store is cleared one entry per
// cycle, with busy high until the pass ends. csr_wr_en/csr_wr_data load
// leaf_count (reset value 1024) and should be written only while idle.
module range_max_segment_tree (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [rmst_pkg::POS_BITS-1:0]     req_position,
   input  logic [rmst_pkg::VALUE_BITS-1:0]   req_update_value,
   input  logic [rmst_pkg::POS_BITS-1:0]     req_range_low,
   input  logic [rmst_pkg::POS_BITS-1:0]     req_range_high,
   output logic                              rsp_valid,
   output logic [rmst_pkg::VALUE_BITS-1:0]   rsp_max_value,
   input  logic                              csr_wr_en,
   input  logic [rmst_pkg::POS_BITS-1:0]     csr_wr_data
);
   import rmst_pkg::*;

   logic [POS_BITS-1:0]   leaf_count_ff;
   mem_req_type           mem_req;
   logic [VALUE_BITS-1:0] rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= POS_BITS'(LEAVES);
      end else if (csr_wr_en) begin
         leaf_count_ff <= csr_wr_data;
      end
   end

   rmst_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_position     (req_position),
      .req_update_value (req_update_value),
      .req_range_low    (req_range_low),
      .req_range_high   (req_range_high),
      .leaf_count       (leaf_count_ff),
      .mem_req          (mem_req),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_max_value    (rsp_max_value)
   );

   rmst_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // A query beat always sets busy in the cycle after it is taken.
   a_query_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_QUERY) |=> busy)
      else $error("query beat taken without the block going busy");

   // A response is only ever produced at the end of a query walk.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("response beat not at the end of a busy period");

   a_rsp_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one beat");

endmodule
